### rtl/bvps_pkg.sv
package bvps_pkg;

   localparam int DOT_W     = 34;
   localparam int MAG_W     = 32;
   localparam int RAT_W     = 17;
   localparam int RAT_STEPS = 16;
   localparam int SCL_W     = 30;
   localparam int DIV_STEPS = 32;
   localparam int SQRT_STEPS = 16;
   localparam int ANG_W     = 27;

   // tilt unit: squares, sums, divider load, quotient steps, root steps
   localparam int TILT_LAT  = 3 + DIV_STEPS + SQRT_STEPS;
   // stage that holds the item after the magnitudes and clamp
   localparam int PREP_STAGE = 3;
   localparam int PIPE_DEPTH = PREP_STAGE + TILT_LAT;
   // stage at which the wrapped angle is ready
   localparam int ANG_STAGE = PREP_STAGE + 1 + RAT_STEPS + 4;
   localparam int ANG_DELAY = PIPE_DEPTH - ANG_STAGE;

   localparam logic [32:0]         NEAR_ZERO_Q28 = 33'd2685;
   localparam logic signed [33:0]  Z_MIN_Q28     = 34'sd26844;
   localparam logic signed [39:0]  QUAD_A        = -40'sd757780;
   localparam logic signed [39:0]  QUAD_B_SH     = 40'sd2854932 <<< 16;
   localparam logic [26:0]         ONE_Q24       = 27'd16777216;

   typedef enum logic [1:0] {
      REG_LIGHT_X = 2'd0,
      REG_LIGHT_Y = 2'd1,
      REG_LIGHT_Z = 2'd2
   } reg_idx_type;

   function automatic logic signed [ANG_W-1:0] oct_angle(input logic [2:0] oct);
      logic signed [ANG_W-1:0] a;
      case (oct)
         3'd0:    a = 27'sd0;
         3'd1:    a = 27'sd4194304;
         3'd2:    a = 27'sd8388608;
         3'd3:    a = -27'sd4194304;
         3'd4:    a = 27'sd16777216;
         3'd5:    a = -27'sd12582912;
         3'd6:    a = -27'sd8388608;
         3'd7:    a = 27'sd12582912;
         default: a = 27'sd0;
      endcase
      return a;
   endfunction

endpackage

### rtl/bvps_tilt.sv
module bvps_tilt (
   input  logic                            clock,
   input  logic                            en,
   input  logic [bvps_pkg::SCL_W-1:0]      sx,
   input  logic [bvps_pkg::SCL_W-1:0]      sy,
   input  logic [bvps_pkg::SCL_W-1:0]      sz,
   output logic [15:0]                     cos_tilt
);

   localparam int DS = bvps_pkg::DIV_STEPS;
   localparam int SS = bvps_pkg::SQRT_STEPS;

   logic [59:0] sqx_ff, sqy_ff, sqz_ff;
   logic [63:0] num_ff, den_ff;

   logic [63:0] drem_ff [0:DS];
   logic [63:0] dden_ff [0:DS];
   logic [31:0] dq_ff   [0:DS];
   logic [63:0] drem_in [1:DS];
   logic [31:0] dq_in   [1:DS];

   logic [31:0] sv_ff  [0:SS];
   logic [31:0] sr_ff  [0:SS];
   logic [31:0] sv_in  [1:SS];
   logic [31:0] sr_in  [1:SS];

   always_comb begin
      for (int k = 1; k <= DS; k++) begin
         logic [63:0] r2;
         r2 = {drem_ff[k-1][62:0], 1'b0};
         if (r2 >= dden_ff[k-1]) begin
            drem_in[k] = r2 - dden_ff[k-1];
            dq_in[k]   = {dq_ff[k-1][30:0], 1'b1};
         end else begin
            drem_in[k] = r2;
            dq_in[k]   = {dq_ff[k-1][30:0], 1'b0};
         end
      end
   end

   // one root bit per stage, trial bit fixed by the stage
   always_comb begin
      for (int k = 1; k <= SS; k++) begin
         logic [32:0] trial;
         logic [31:0] bitv;
         bitv  = 32'd1 << (32 - 2*k);
         trial = {1'b0, sr_ff[k-1]} + {1'b0, bitv};
         if ({1'b0, sv_ff[k-1]} >= trial) begin
            sv_in[k] = sv_ff[k-1] - trial[31:0];
            sr_in[k] = (sr_ff[k-1] >> 1) + bitv;
         end else begin
            sv_in[k] = sv_ff[k-1];
            sr_in[k] = sr_ff[k-1] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= sx * sx;
         sqy_ff <= sy * sy;
         sqz_ff <= sz * sz;
         num_ff <= 64'(sqx_ff) + 64'(sqy_ff);
         den_ff <= 64'(sqx_ff) + 64'(sqy_ff) + 64'(sqz_ff);
         drem_ff[0] <= num_ff;
         dden_ff[0] <= den_ff;
         dq_ff[0]   <= '0;
         for (int k = 1; k <= DS; k++) begin
            drem_ff[k] <= drem_in[k];
            dden_ff[k] <= dden_ff[k-1];
            dq_ff[k]   <= dq_in[k];
         end
         // quotient enters the root chain on the last divide stage
         sv_ff[0] <= dq_in[DS];
         sr_ff[0] <= '0;
         for (int k = 1; k <= SS; k++) begin
            sv_ff[k] <= sv_in[k];
            sr_ff[k] <= sr_in[k];
         end
      end
   end

   assign cos_tilt = sr_ff[SS][15:0];

endmodule

### rtl/bump_vertex_polar_shader.sv
// Per-vertex polar bump angle unit. Takes one vertex per clock when the
// result side keeps up. Its tilt path is a 32-step restoring divider and a
// 16-step square root, one step per stage. A one-item skid buffer on the
// result side lets the pipe take one more vertex while a result waits.
// The light direction registers (x at 0x0, y at 0x4, z at 0x8) must only
// be written while idle.
module bump_vertex_polar_shader (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_tangent_x,
   input  logic signed [15:0] req_tangent_y,
   input  logic signed [15:0] req_tangent_z,
   input  logic signed [15:0] req_bitangent_x,
   input  logic signed [15:0] req_bitangent_y,
   input  logic signed [15:0] req_bitangent_z,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic [15:0]        req_angle_offset,
   input  logic               req_last_vertex,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_cos_tilt,
   output logic [15:0]        rsp_bump_angle,
   output logic               rsp_last_out,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int DEPTH = bvps_pkg::PIPE_DEPTH;
   localparam int RS    = bvps_pkg::RAT_STEPS;
   localparam int AD    = bvps_pkg::ANG_DELAY;
   localparam int MW    = bvps_pkg::MAG_W;
   localparam int SW    = bvps_pkg::SCL_W;

   logic signed [15:0] light_x_ff, light_y_ff, light_z_ff;
   logic               en;
   logic [1:DEPTH]     v_ff;

   // ---- configuration ----
   bvps_pkg::reg_idx_type csr_idx;
   assign csr_idx    = bvps_pkg::reg_idx_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= 16'sd0;
         light_y_ff <= 16'sd0;
         light_z_ff <= 16'sd16384;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            bvps_pkg::REG_LIGHT_X: light_x_ff <= csr_pwdata[15:0];
            bvps_pkg::REG_LIGHT_Y: light_y_ff <= csr_pwdata[15:0];
            bvps_pkg::REG_LIGHT_Z: light_z_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         bvps_pkg::REG_LIGHT_X: csr_prdata = 32'(light_x_ff);
         bvps_pkg::REG_LIGHT_Y: csr_prdata = 32'(light_y_ff);
         bvps_pkg::REG_LIGHT_Z: csr_prdata = 32'(light_z_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // ---- flow control ----
   logic        skid_full_ff;
   logic [15:0] skid_cos_ff, skid_ang_ff;
   logic        skid_last_ff;

   assign en        = !skid_full_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {req_valid, v_ff[1:DEPTH-1]};
      end
   end

   // ---- stage 1: products ----
   logic signed [31:0] p_ff [0:8];
   logic [15:0]        off1_ff, off2_ff, off3_ff;
   logic               last1_ff, last2_ff, last3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= req_tangent_x * light_x_ff;
         p_ff[1] <= req_tangent_y * light_y_ff;
         p_ff[2] <= req_tangent_z * light_z_ff;
         p_ff[3] <= req_bitangent_x * light_x_ff;
         p_ff[4] <= req_bitangent_y * light_y_ff;
         p_ff[5] <= req_bitangent_z * light_z_ff;
         p_ff[6] <= req_normal_x * light_x_ff;
         p_ff[7] <= req_normal_y * light_y_ff;
         p_ff[8] <= req_normal_z * light_z_ff;
         off1_ff  <= req_angle_offset;
         last1_ff <= req_last_vertex;
      end
   end

   // ---- stage 2: dots ----
   logic signed [bvps_pkg::DOT_W-1:0] x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= 34'(p_ff[0]) + 34'(p_ff[1]) + 34'(p_ff[2]);
         y_ff <= 34'(p_ff[3]) + 34'(p_ff[4]) + 34'(p_ff[5]);
         z_ff <= 34'(p_ff[6]) + 34'(p_ff[7]) + 34'(p_ff[8]);
         off2_ff  <= off1_ff;
         last2_ff <= last1_ff;
      end
   end

   // ---- stage 3: magnitudes, octant, clamp ----
   logic signed [bvps_pkg::DOT_W-1:0] xa_s, ya_s, zc_s;
   logic [MW-1:0] ax, ay, num_in, den_in;
   logic          near;
   logic [2:0]    oct_in;
   logic [MW-1:0] num3_ff, den3_ff;
   logic [2:0]    oct3_ff;
   logic [SW-1:0] sx_ff, sy_ff, sz_ff;

   always_comb begin
      xa_s = x_ff[bvps_pkg::DOT_W-1] ? -x_ff : x_ff;
      ya_s = y_ff[bvps_pkg::DOT_W-1] ? -y_ff : y_ff;
      ax   = xa_s[MW-1:0];
      ay   = ya_s[MW-1:0];
      zc_s = (z_ff < bvps_pkg::Z_MIN_Q28) ? bvps_pkg::Z_MIN_Q28 : z_ff;
      near = ({1'b0, ax} + {1'b0, ay}) < bvps_pkg::NEAR_ZERO_Q28;
      oct_in[1] = x_ff[bvps_pkg::DOT_W-1];
      oct_in[2] = y_ff[bvps_pkg::DOT_W-1];
      if (near) begin
         oct_in[0] = 1'b0;
         num_in    = '0;
         den_in    = 32'd1;
      end else if (ax > ay) begin
         oct_in[0] = 1'b0;
         num_in    = ay;
         den_in    = ax;
      end else begin
         oct_in[0] = 1'b1;
         num_in    = ax;
         den_in    = ay;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num3_ff  <= num_in;
         den3_ff  <= den_in;
         oct3_ff  <= oct_in;
         sx_ff    <= ax[MW-1:2];
         sy_ff    <= ay[MW-1:2];
         sz_ff    <= zc_s[MW-1:2];
         off3_ff  <= off2_ff;
         last3_ff <= last2_ff;
      end
   end

   // ---- ratio divider: top bit, then one bit per stage ----
   logic [MW-1:0]             rrem_ff [0:RS];
   logic [MW-1:0]             rden_ff [0:RS];
   logic [bvps_pkg::RAT_W-1:0] rq_ff  [0:RS];
   logic [2:0]                roct_ff [0:RS];
   logic [15:0]               roff_ff [0:RS];
   logic                      rlast_ff [0:RS];
   logic [MW-1:0]             rrem_in [1:RS];
   logic                      rbit_in [1:RS];

   always_comb begin
      for (int k = 1; k <= RS; k++) begin
         logic [MW:0] r2;
         r2 = {rrem_ff[k-1], 1'b0};
         rbit_in[k] = r2 >= {1'b0, rden_ff[k-1]};
         rrem_in[k] = rbit_in[k] ? MW'(r2 - {1'b0, rden_ff[k-1]}) : r2[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rq_ff[0]    <= 17'(num3_ff >= den3_ff);
         rrem_ff[0]  <= (num3_ff >= den3_ff) ? num3_ff - den3_ff : num3_ff;
         rden_ff[0]  <= den3_ff;
         roct_ff[0]  <= oct3_ff;
         roff_ff[0]  <= off3_ff;
         rlast_ff[0] <= last3_ff;
         for (int k = 1; k <= RS; k++) begin
            rrem_ff[k]  <= rrem_in[k];
            rden_ff[k]  <= rden_ff[k-1];
            rq_ff[k]    <= {rq_ff[k-1][bvps_pkg::RAT_W-2:0], rbit_in[k]};
            roct_ff[k]  <= roct_ff[k-1];
            roff_ff[k]  <= roff_ff[k-1];
            rlast_ff[k] <= rlast_ff[k-1];
         end
      end
   end

   // ---- quadratic atan and angle ----
   logic signed [39:0] t_ff;
   logic [16:0]        r21_ff;
   logic [2:0]         oct21_ff, oct22_ff;
   logic [15:0]        off21_ff, off22_ff;
   logic               last21_ff, last22_ff, last23_ff;
   logic [54:0]        prod_ff;
   logic [26:0]        ang23_ff;
   logic [55:0]        prod_rnd;
   logic signed [26:0] diff;
   logic [26:0]        ang_in, angw;
   logic [18:0]        ang_r;
   logic [15:0]        ad_ff [0:AD];
   logic               ld_ff [0:AD];

   always_comb begin
      prod_rnd = {1'b0, prod_ff} + 56'(32'h8000_0000);
      diff     = $signed({3'b000, prod_rnd[55:32]}) - bvps_pkg::oct_angle(oct22_ff);
      ang_in   = 27'(diff[26] ? -diff : diff) + {3'b000, off22_ff, 8'd0};
      angw     = (ang23_ff > bvps_pkg::ONE_Q24) ? ang23_ff - bvps_pkg::ONE_Q24 : ang23_ff;
      ang_r    = 19'((angw + 27'd128) >> 8);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff      <= bvps_pkg::QUAD_A * $signed({23'd0, rq_ff[RS]})
                      + bvps_pkg::QUAD_B_SH;
         r21_ff    <= rq_ff[RS];
         oct21_ff  <= roct_ff[RS];
         off21_ff  <= roff_ff[RS];
         last21_ff <= rlast_ff[RS];
         prod_ff   <= 55'(t_ff[37:0] * r21_ff);
         oct22_ff  <= oct21_ff;
         off22_ff  <= off21_ff;
         last22_ff <= last21_ff;
         ang23_ff  <= ang_in;
         last23_ff <= last22_ff;
         ad_ff[0]  <= (ang_r > 19'd65535) ? 16'hFFFF : ang_r[15:0];
         ld_ff[0]  <= last23_ff;
         for (int k = 1; k <= AD; k++) begin
            ad_ff[k] <= ad_ff[k-1];
            ld_ff[k] <= ld_ff[k-1];
         end
      end
   end

   // ---- tilt ----
   logic [15:0] cos_out;

   bvps_tilt u_tilt (
      .clock    (clock),
      .en       (en),
      .sx       (sx_ff),
      .sy       (sy_ff),
      .sz       (sz_ff),
      .cos_tilt (cos_out)
   );

   // ---- result skid ----
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ready) skid_full_ff <= 1'b0;
      end else if (v_ff[DEPTH] && !rsp_ready) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff) begin
         skid_cos_ff  <= cos_out;
         skid_ang_ff  <= ad_ff[AD];
         skid_last_ff <= ld_ff[AD];
      end
   end

   assign rsp_valid      = skid_full_ff || v_ff[DEPTH];
   assign rsp_cos_tilt   = skid_full_ff ? skid_cos_ff  : cos_out;
   assign rsp_bump_angle = skid_full_ff ? skid_ang_ff  : ad_ff[AD];
   assign rsp_last_out   = skid_full_ff ? skid_last_ff : ld_ff[AD];

endmodule
